FILE: hdl/hvt_pkg.sv
package hvt_pkg;

  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = 3;
  localparam int WORD_W = 32;
  localparam int REG_W = 64;

  // Reset values of the matrix registers (identity).
  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  // Sideband that travels with an item through the pipeline.
  typedef struct packed {
    logic dir;
    logic ovf;
    logic divided;
  } item_flags_t;

endpackage

FILE: hdl/hvt_if.sv
interface hvt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic               is_direction;
  modport source (output valid, x, y, z, is_direction, input ready);
  modport sink (input valid, x, y, z, is_direction, output ready);
endinterface

interface hvt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic               divided;
  logic               overflow;
  modport source (output valid, x, y, z, divided, overflow, input ready);
  modport sink (input valid, x, y, z, divided, overflow, output ready);
endinterface

interface hvt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/hvt_matmul.sv
// Multiply and accumulate stages: products registered, then row sums saturated.
// Two register stages; advances when en is high.
module hvt_matmul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [31:0]         in_x,
  input  logic signed [31:0]         in_y,
  input  logic signed [31:0]         in_z,
  input  logic                       in_dir,
  input  logic [63:0]                mat [8],
  output logic                       out_valid,
  output logic signed [31:0]         out_r [4],
  output hvt_pkg::item_flags_t       out_flags
);

  localparam int PW = 64;

  logic signed [PW-1:0] prod_r [12];
  logic signed [31:0]   trans_r [4];
  logic                 v1_r;
  logic                 dir1_r;
  logic signed [PW-1:0] prod_nxt [12];
  logic signed [31:0]   sum_sat [4];
  logic [3:0]           sum_ovf;

  function automatic logic signed [31:0] entry_f(input logic [63:0] m [8], input int i);
    logic [63:0] r;
    r = m[i/2];
    return (i % 2 == 1) ? r[63:32] : r[31:0];
  endfunction

  // Truncate-toward-zero products of each vector element by each entry of its matrix row.
  always_comb begin
    logic signed [31:0] vk;
    logic signed [31:0] e;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [63:0] ps;
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 4; c++) begin
        vk = (k == 0) ? in_x : (k == 1) ? in_y : in_z;
        e = entry_f(mat, k * 4 + c);
        ma = vk[31] ? 32'(-vk) : 32'(vk);
        mb = e[31] ? 32'(-e) : 32'(e);
        p = 64'(ma) * 64'(mb);
        ps = p >> FRAC_BITS;
        prod_nxt[k * 4 + c] = (vk[31] ^ e[31]) ? -$signed(ps) : $signed(ps);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      out_valid <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      dir1_r <= in_dir;
      for (int c = 0; c < 4; c++) begin
        trans_r[c] <= in_dir ? 32'sd0 : entry_f(mat, 12 + c);
      end
    end
  end

  // Row sums with saturation; w is forced to zero for a direction.
  always_comb begin
    logic signed [PW+1:0] s;
    for (int c = 0; c < 4; c++) begin
      s = (PW+2)'(prod_r[c]) + (PW+2)'(prod_r[4 + c]) + (PW+2)'(prod_r[8 + c])
          + (PW+2)'(trans_r[c]);
      if (dir1_r && c == 3) begin
        sum_sat[c] = 32'sd0;
        sum_ovf[c] = 1'b0;
      end else if (s > (PW+2)'(64'sd2147483647)) begin
        sum_sat[c] = 32'sh7fffffff;
        sum_ovf[c] = 1'b1;
      end else if (s < -(PW+2)'(64'sd2147483648)) begin
        sum_sat[c] = 32'sh80000000;
        sum_ovf[c] = 1'b1;
      end else begin
        sum_sat[c] = s[31:0];
        sum_ovf[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= sum_sat;
      out_flags.dir <= dir1_r;
      out_flags.ovf <= |sum_ovf;
      out_flags.divided <= 1'b0;
    end
  end

endmodule

FILE: hdl/hvt_div.sv
// Pipelined restoring divider for x, y, z by w: one quotient bit per stage.
// Setup stage, quotient-bit stages and an output stage; advances when en is high.
module hvt_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [31:0]    in_r [4],
  input  hvt_pkg::item_flags_t  in_flags,
  output logic                  out_valid,
  output logic signed [31:0]    out_x,
  output logic signed [31:0]    out_y,
  output logic signed [31:0]    out_z,
  output logic                  out_divided,
  output logic                  out_overflow
);

  localparam int QW = 32 + FRAC_BITS;
  localparam int NS = QW;

  typedef struct packed {
    logic [2:0][QW-1:0] num;
    logic [2:0][32:0]   rem;
    logic [2:0]         neg;
    logic [2:0][31:0]   orig;
    logic [31:0]        den;
    logic               div;
    logic               ovf;
  } div_stage_t;

  div_stage_t st_r [NS+1];
  logic       vld_r [NS+1];
  div_stage_t st_nxt [NS+1];

  // Stage 0 setup: magnitudes and the decision whether to divide.
  always_comb begin
    logic [31:0] w;
    logic [31:0] a;
    w = in_r[3];
    st_nxt[0] = '0;
    st_nxt[0].den = w[31] ? 32'(-w) : w;
    st_nxt[0].div = !in_flags.dir && (w != 32'd0) && (w != (32'd1 << FRAC_BITS));
    st_nxt[0].ovf = in_flags.ovf;
    for (int c = 0; c < 3; c++) begin
      a = in_r[c];
      st_nxt[0].orig[c] = a;
      st_nxt[0].neg[c] = a[31] ^ w[31];
      st_nxt[0].num[c] = QW'(a[31] ? 32'(-a) : a) << FRAC_BITS;
    end
  end

  // One quotient bit per stage; quotient bits shift into num from the right.
  for (genvar s = 1; s <= NS; s++) begin : g_step
    always_comb begin
      logic [33:0] t;
      st_nxt[s] = st_r[s-1];
      for (int c = 0; c < 3; c++) begin
        t = {st_r[s-1].rem[c], st_r[s-1].num[c][QW-1]} - {2'b00, st_r[s-1].den};
        st_nxt[s].num[c] = {st_r[s-1].num[c][QW-2:0], !t[33]};
        st_nxt[s].rem[c] = t[33] ? {st_r[s-1].rem[c][31:0], st_r[s-1].num[c][QW-1]}
                                 : t[32:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NS; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s <= NS; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s <= NS; s++) st_r[s] <= st_nxt[s];
    end
  end

  // Sign and saturate the quotients, or pass the sums through.
  logic [2:0][31:0] res;
  logic [2:0]       qovf;
  always_comb begin
    logic [QW-1:0] q;
    for (int c = 0; c < 3; c++) begin
      q = st_r[NS].num[c];
      qovf[c] = 1'b0;
      if (!st_r[NS].div) begin
        res[c] = st_r[NS].orig[c];
      end else if (st_r[NS].neg[c]) begin
        if (q > QW'(33'h080000000)) begin
          res[c] = 32'h80000000;
          qovf[c] = 1'b1;
        end else begin
          res[c] = 32'(-q);
        end
      end else if (q > QW'(32'h7fffffff)) begin
        res[c] = 32'h7fffffff;
        qovf[c] = 1'b1;
      end else begin
        res[c] = q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= res[0];
      out_y <= res[1];
      out_z <= res[2];
      out_divided <= st_r[NS].div;
      out_overflow <= st_r[NS].ovf | (st_r[NS].div & |qovf);
    end
  end

endmodule

FILE: hdl/homogeneous_vertex_transform.sv
// Homogeneous vertex transform: each transaction carries one signed fixed-point
// vertex (FRAC_BITS fraction bits) that is multiplied by a row-major 4x4 matrix,
// translated and divided by a nonzero w for points. The pipeline takes one
// vertex every cycle while the output is not stalled; it has two
// multiply/sum stages, one divider setup stage, one stage per quotient bit
// and one output stage. Backpressure on the output stalls the whole pipeline:
// while a finished result waits, the input ready follows the output ready.
// Matrix writes are taken at any time but must only occur when idle.
module homogeneous_vertex_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  hvt_in_if.sink         in_ch,
  hvt_out_if.source      out_ch,
  hvt_cfg_if.sink        cfg_ch
);

  logic [63:0] mat_r [8];
  logic        en;
  logic        mm_valid;
  logic signed [31:0] mm_r [4];
  hvt_pkg::item_flags_t mm_flags;
  logic        pipe_valid;
  logic signed [31:0] px, py, pz;
  logic        pdiv, povf;

  // Matrix registers.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hvt_pkg::NUM_REGS; i++) mat_r[i] <= hvt_pkg::REG_RESET[i];
    end else if (cfg_ch.valid) begin
      mat_r[cfg_ch.index] <= cfg_ch.data;
    end
  end

  // The pipeline advances unless a result sits unaccepted at the output.
  assign en = !pipe_valid || out_ch.ready;
  assign in_ch.ready = en;

  hvt_matmul #(.FRAC_BITS(FRAC_BITS)) u_mm (
    .clk, .rst_n, .en,
    .in_valid(in_ch.valid), .in_x(in_ch.x), .in_y(in_ch.y), .in_z(in_ch.z),
    .in_dir(in_ch.is_direction), .mat(mat_r),
    .out_valid(mm_valid), .out_r(mm_r), .out_flags(mm_flags)
  );

  hvt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n, .en,
    .in_valid(mm_valid), .in_r(mm_r), .in_flags(mm_flags),
    .out_valid(pipe_valid), .out_x(px), .out_y(py), .out_z(pz),
    .out_divided(pdiv), .out_overflow(povf)
  );

  assign out_ch.valid = pipe_valid;
  assign out_ch.x = px;
  assign out_ch.y = py;
  assign out_ch.z = pz;
  assign out_ch.divided = pdiv;
  assign out_ch.overflow = povf;

endmodule
